/* hdl/axs_pkg.sv */
// ----------------------------------------------------------------------------
// axs_pkg
// Types and decode constants shared by the address reference scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package axs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OffW  = 48;
  localparam int unsigned ValW  = 64;
  localparam int unsigned RegN  = 32;
  localparam int unsigned RegW  = 5;

  localparam logic [WordW-1:0] AdrpMask    = 32'h9F00_0000;
  localparam logic [WordW-1:0] AdrpMatch   = 32'h9000_0000;
  localparam logic [WordW-1:0] AddMask     = 32'hFF00_0000;
  localparam logic [WordW-1:0] AddMatch    = 32'h9100_0000;
  localparam logic [WordW-1:0] LdrMask     = 32'hF9C0_0000;
  localparam logic [WordW-1:0] LdrMatch    = 32'hF940_0000;
  localparam logic [WordW-1:0] AdrMask     = 32'h9F00_0000;
  localparam logic [WordW-1:0] AdrMatch    = 32'h1000_0000;
  localparam logic [WordW-1:0] LitMask     = 32'hFF00_0000;
  localparam logic [WordW-1:0] LitMatch    = 32'h5800_0000;
  localparam logic [WordW-1:0] LitImmMask  = 32'h00FF_FFE0;
  localparam logic [WordW-1:0] ImmLoMask   = 32'h6000_0000;

  // what the back end does with a decoded word
  typedef enum logic [1:0] {
    OP_NONE,   // no write, compare only
    OP_SKIP,   // no write, no compare
    OP_CONST,  // write precomputed value
    OP_ADD     // write rn + operand
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            check;
    logic            scan_start;
    logic [RegW-1:0] rd;
    logic [RegW-1:0] rn;
    logic [ValW-1:0] operand;
    logic [OffW-1:0] pos;
  } item_t;

endpackage

`default_nettype wire

/* hdl/axs_if.sv */
// ----------------------------------------------------------------------------
// axs_if
// Valid/ready channels for instruction items and scan results.
// ----------------------------------------------------------------------------
`default_nettype none

interface axs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [47:0] byte_offset;
  logic        scan_start;

  modport source (output valid, instr_word, byte_offset, scan_start, input ready);
  modport sink (input valid, instr_word, byte_offset, scan_start, output ready);
endinterface

interface axs_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] hit_offset;

  modport source (output valid, hit, hit_offset, input ready);
  modport sink (input valid, hit, hit_offset, output ready);
endinterface

`default_nettype wire

/* hdl/axs_front.sv */
// ----------------------------------------------------------------------------
// axs_front
// Accepts instruction words, decodes them and forms register-free values.
// ----------------------------------------------------------------------------
`default_nettype none

module axs_front (
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [axs_pkg::WordW-1:0] instr_word_i,
  input  wire logic [axs_pkg::OffW-1:0]  byte_offset_i,
  input  wire logic                      scan_start_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output axs_pkg::item_t                 item_o
);

  logic [axs_pkg::WordW-1:0] w;
  logic [axs_pkg::OffW-1:0]  pos;
  logic [axs_pkg::ValW-1:0]  pos64;
  logic [axs_pkg::ValW-1:0]  imm21;
  logic [axs_pkg::ValW-1:0]  imm12;
  logic [axs_pkg::ValW-1:0]  lit;
  logic [axs_pkg::ValW-1:0]  base;
  logic [axs_pkg::ValW-1:0]  addend;
  logic                      is_adrp;
  logic                      is_adr;

  assign w      = instr_word_i;
  assign pos    = {byte_offset_i[axs_pkg::OffW-1:2], 2'b00};
  assign pos64  = {{(axs_pkg::ValW-axs_pkg::OffW){1'b0}}, pos};
  assign imm21  = {{43{w[23]}}, w[23:5], w[30:29]};
  assign imm12  = {52'd0, w[21:10]};
  assign lit    = axs_pkg::ValW'((w & axs_pkg::LitImmMask) >> 3);

  assign is_adrp = (w & axs_pkg::AdrpMask) == axs_pkg::AdrpMatch;
  assign is_adr  = (w & axs_pkg::AdrMask) == axs_pkg::AdrMatch;

  // one adder for all pc-relative forms
  always_comb begin
    if (is_adrp) begin
      base   = {pos64[axs_pkg::ValW-1:12], 12'd0};
      addend = {imm21[axs_pkg::ValW-13:0], 12'd0};
    end else if (is_adr) begin
      base   = pos64;
      addend = imm21;
    end else begin
      base   = pos64;
      addend = lit;
    end
  end

  always_comb begin
    item_o.rd         = w[4:0];
    item_o.rn         = w[9:5];
    item_o.pos        = pos;
    item_o.scan_start = scan_start_i;
    item_o.check      = 1'b1;
    item_o.op         = axs_pkg::OP_NONE;
    item_o.operand    = base + addend;
    priority if (is_adrp) begin
      item_o.op    = axs_pkg::OP_CONST;
      item_o.check = 1'b0;
    end else if ((w & axs_pkg::AddMask) == axs_pkg::AddMatch) begin
      if (w[23]) begin
        item_o.op    = axs_pkg::OP_SKIP;
        item_o.check = 1'b0;
      end else begin
        item_o.op      = axs_pkg::OP_ADD;
        item_o.operand = w[22] ? {imm12[axs_pkg::ValW-13:0], 12'd0} : imm12;
      end
    end else if ((w & axs_pkg::LdrMask) == axs_pkg::LdrMatch) begin
      if (w[21:10] == 12'd0) begin
        item_o.op    = axs_pkg::OP_SKIP;
        item_o.check = 1'b0;
      end else begin
        item_o.op      = axs_pkg::OP_ADD;
        item_o.operand = {imm12[axs_pkg::ValW-4:0], 3'd0};
      end
    end else if (is_adr) begin
      item_o.op = axs_pkg::OP_CONST;
    end else if ((w & axs_pkg::LitMask) == axs_pkg::LitMatch) begin
      item_o.op = axs_pkg::OP_CONST;
    end else begin
      item_o.op = axs_pkg::OP_NONE;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

/* hdl/axs_fifo.sv */
// ----------------------------------------------------------------------------
// axs_fifo
// Short queue of decoded items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module axs_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire axs_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output axs_pkg::item_t      head_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  axs_pkg::item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = count_q == CntW'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != CntW'(DEPTH))
    else $error("push into full queue");

endmodule

`default_nettype wire

/* hdl/axs_back.sv */
// ----------------------------------------------------------------------------
// axs_back
// Register tracking: reads sources, adds, writes back, compares with target.
// ----------------------------------------------------------------------------
`default_nettype none

module axs_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      head_valid_i,
  input  wire axs_pkg::item_t            head_i,
  output logic                           pop_o,
  input  wire logic [axs_pkg::ValW-1:0]  target_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           hit_o,
  output logic [axs_pkg::OffW-1:0]       hit_offset_o
);

  logic [axs_pkg::ValW-1:0] mem_q [axs_pkg::RegN];
  logic [axs_pkg::RegN-1:0] valid_q, valid_d;
  logic [axs_pkg::ValW-1:0] rn_data_q, rd_data_q;
  logic [axs_pkg::RegW-1:0] fwd_addr_q;
  logic [axs_pkg::ValW-1:0] fwd_data_q;
  axs_pkg::item_t           ex_q;
  logic                     ex_valid_q;
  logic                     out_valid_q;
  logic                     hit_q;
  logic [axs_pkg::OffW-1:0] hit_offset_q;

  logic                     fire;
  logic                     advance;
  logic                     wr_en;
  logic [axs_pkg::ValW-1:0] rn_val, rd_val, new_val, cmp_val;
  logic                     hit_d;

  assign fire    = ex_valid_q && (!out_valid_q || out_ready_i);
  assign advance = head_valid_i && (!ex_valid_q || fire);
  assign pop_o   = advance;
  assign wr_en   = fire && (ex_q.op == axs_pkg::OP_CONST || ex_q.op == axs_pkg::OP_ADD);

  // operand values as seen after all earlier items
  always_comb begin
    if (ex_q.scan_start || !valid_q[ex_q.rn]) rn_val = '0;
    else if (fwd_addr_q == ex_q.rn) rn_val = fwd_data_q;
    else rn_val = rn_data_q;
    if (ex_q.scan_start || !valid_q[ex_q.rd]) rd_val = '0;
    else if (fwd_addr_q == ex_q.rd) rd_val = fwd_data_q;
    else rd_val = rd_data_q;
  end

  assign new_val = (ex_q.op == axs_pkg::OP_ADD) ? rn_val + ex_q.operand : ex_q.operand;
  assign cmp_val = (ex_q.op == axs_pkg::OP_CONST || ex_q.op == axs_pkg::OP_ADD) ?
                   new_val : rd_val;
  assign hit_d   = ex_q.check && (cmp_val == target_i);

  always_comb begin
    valid_d = valid_q;
    if (fire && ex_q.scan_start) valid_d = '0;
    if (wr_en) valid_d[ex_q.rd] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ex_q.rd] <= new_val;
      fwd_addr_q     <= ex_q.rd;
      fwd_data_q     <= new_val;
    end
    if (advance) begin
      rn_data_q <= mem_q[head_i.rn];
      rd_data_q <= mem_q[head_i.rd];
      ex_q      <= head_i;
    end
    if (fire) begin
      hit_q        <= hit_d;
      hit_offset_q <= hit_d ? ex_q.pos : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (advance) ex_valid_q <= 1'b1;
      else if (fire) ex_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign hit_offset_o = hit_offset_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ex_q.scan_start |=> $onehot0(valid_q))
    else $error("scan start left stale registers valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !ex_q.check |=> out_valid_q && !hit_q)
    else $error("hit reported for unchecked word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hit_q |-> hit_offset_q == '0)
    else $error("offset nonzero without hit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(ex_q.rd)])
    else $error("written register not marked valid");

endmodule

`default_nettype wire

/* hdl/arm64_address_xref_scanner_top.sv */
// ----------------------------------------------------------------------------
// arm64_address_xref_scanner_top
// Tracks ADRP/ADD/LDR/ADR address formation per register and flags words
// whose destination register reaches the target address.
//
//   channel   dir  handshake             payload
//   in_i      in   valid/ready           instr_word, byte_offset, scan_start
//   out_o     out  valid/ready           hit, hit_offset
//   apb       in   psel/penable/pready   paddr, pwdata, prdata (target_address)
//
// one item per cycle sustained while the output is not held; an accepted item
// passes the queue, execute and output stages on its way to the result
// the execute stage's register read, 64-bit add and compare set the rate
// reset clears the queue, pipeline valids, register valid bits and target
// a held output fills the execute stage, then the queue, then drops in ready
// ----------------------------------------------------------------------------
`default_nettype none

module arm64_address_xref_scanner_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  axs_in_if.sink           in_i,
  axs_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] AddrTarget = 4'h0;

  logic [axs_pkg::ValW-1:0] target_q;
  logic                     q_full;
  logic                     push;
  logic                     pop;
  logic                     head_valid;
  axs_pkg::item_t           item;
  axs_pkg::item_t           head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && paddr == AddrTarget) begin
      target_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrTarget) ? target_q : '0;

  axs_front u_front (
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .instr_word_i  (in_i.instr_word),
    .byte_offset_i (in_i.byte_offset),
    .scan_start_i  (in_i.scan_start),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (item)
  );

  axs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  axs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .target_i     (target_q),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .hit_o        (out_o.hit),
    .hit_offset_o (out_o.hit_offset)
  );

endmodule

`default_nettype wire
